>>> hw/rtl/agsr_pkg.sv
// Shared types, constants and register codes of the gain scaler and level meter.
package agsr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 16;
   localparam int BOOST_W     = 5;
   localparam int DECAY_W     = 16;
   localparam int LEVEL_W     = 16;
   localparam int OP_W        = 2;
   localparam int ENERGY_W    = 40;
   localparam int ROOT_W      = ENERGY_W / 2;
   localparam int MUL_A_W     = ROOT_W;
   localparam int MUL_B_W     = 16;
   localparam int MUL_W       = MUL_A_W + MUL_B_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int BLOCK_MAX_DEF   = 256;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Item kinds.
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME_GAIN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_BOOST  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_FACTOR = 2'd2;

   // Register reset values.
   localparam logic [GAIN_W-1:0]  VOLUME_GAIN_RST  = 16'd16384;
   localparam logic [BOOST_W-1:0] LEVEL_BOOST_RST  = 5'd4;
   localparam logic [DECAY_W-1:0] DECAY_FACTOR_RST = 16'd52429;

   typedef struct packed {
      logic [GAIN_W-1:0]  volume_gain;
      logic [BOOST_W-1:0] level_boost;
      logic [DECAY_W-1:0] decay_factor;
   } agsr_cfg_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      logic [OP_W-1:0]            op;
      logic signed [SAMPLE_W-1:0] scaled;
      logic                       last;
   } agsr_item_type;

endpackage

>>> hw/rtl/agsr_front.sv
// Front end: accepts items, applies the volume gain and pushes them into the queue.
module agsr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [agsr_pkg::GAIN_W-1:0]  volume_gain,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [agsr_pkg::SAMPLE_W-1:0] req_tdata,
   input  logic [agsr_pkg::OP_W-1:0]    req_tuser,
   input  logic                         req_tlast,
   input  logic                         queue_full,
   output logic                         queue_push,
   output agsr_pkg::agsr_item_type      queue_item
);
   import agsr_pkg::*;

   localparam int PROD_W = 34;

   logic                     stg_valid_ff, stg_valid_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [OP_W-1:0]          op_ff;
   logic                     last_ff;
   logic                     take;
   logic signed [PROD_W-1:0] biased;
   logic signed [19:0]       quot;
   logic signed [SAMPLE_W-1:0] scaled;

   assign queue_push = stg_valid_ff && !queue_full;
   assign req_tready = !stg_valid_ff || !queue_full;
   assign take       = req_tvalid && req_tready;

   assign prod_in = $signed({{(PROD_W-SAMPLE_W){req_tdata[SAMPLE_W-1]}}, req_tdata})
                  * $signed({{(PROD_W-GAIN_W){1'b0}}, volume_gain});

   // Truncate toward zero: bias negative products before the arithmetic shift.
   assign biased = prod_ff + (prod_ff[PROD_W-1] ? 34'sd16383 : 34'sd0);
   assign quot   = biased[PROD_W-1:14];

   always_comb begin
      if (quot > 20'sd32767) begin
         scaled = 16'sh7FFF;
      end else if (quot < -20'sd32768) begin
         scaled = 16'sh8000;
      end else begin
         scaled = quot[SAMPLE_W-1:0];
      end
   end

   assign queue_item = '{op: op_ff, scaled: scaled, last: last_ff};

   always_comb begin
      if (take) begin
         stg_valid_in = 1'b1;
      end else if (queue_push) begin
         stg_valid_in = 1'b0;
      end else begin
         stg_valid_in = stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         prod_ff <= prod_in;
         op_ff   <= req_tuser;
         last_ff <= req_tlast;
      end
   end

endmodule

>>> hw/rtl/agsr_fifo.sv
// Short queue of classified items between the front end and the back end.
module agsr_fifo #(
   parameter int DEPTH = agsr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  agsr_pkg::agsr_item_type push_item,
   input  logic                    pop,
   output agsr_pkg::agsr_item_type head_item,
   output logic                    full,
   output logic                    empty
);
   import agsr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   agsr_item_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == NW'(DEPTH));
   assign empty     = (fill_ff == '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NW'(DEPTH))
      else $error("queue fill count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from an empty queue");
`endif

endmodule

>>> hw/rtl/agsr_back.sv
// Back end: energy accumulation, block mean, square root, level decay and result register.
module agsr_back #(
   parameter int BLOCK_MAX = agsr_pkg::BLOCK_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  agsr_pkg::agsr_cfg_type        cfg,
   input  logic                          queue_empty,
   input  agsr_pkg::agsr_item_type       queue_item,
   output logic                          queue_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic                          rsp_sample_valid,
   output logic [agsr_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic [agsr_pkg::LEVEL_W-1:0]  rsp_level
);
   import agsr_pkg::*;

   localparam int CW        = $clog2(BLOCK_MAX + 1);
   localparam int STEP_W    = $clog2(ENERGY_W);
   localparam int SQ_W      = 2 * SAMPLE_W - 1;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_EXEC  = 9'b000000010,
      S_ACCUM = 9'b000000100,
      S_DIV   = 9'b000001000,
      S_ROOT  = 9'b000010000,
      S_BOOST = 9'b000100000,
      S_CLAMP = 9'b001000000,
      S_DECAY = 9'b010000000,
      S_EMIT  = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   agsr_item_type         item_ff, item_in;
   logic [ENERGY_W-1:0]   energy_ff, energy_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         div_ff, div_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [MUL_W-1:0]      mul_ff, mul_in;
   logic [ENERGY_W-1:0]   work_ff, work_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic [ENERGY_W-1:0]   res_ff, res_in;
   logic [ENERGY_W-1:0]   bit_ff, bit_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_user_ff;
   logic [SAMPLE_W-1:0]   out_sample_ff;
   logic [LEVEL_W-1:0]    out_level_ff;

   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic [SAMPLE_W-1:0]   mag;
   logic [ENERGY_W:0]     acc_sum;
   logic [ENERGY_W-1:0]   acc_sat;
   logic [CW-1:0]         cnt_next;
   logic                  close;
   logic [CW:0]           trial;
   logic [CW:0]           trial_diff;
   logic                  div_ge;
   logic [ENERGY_W-1:0]   root_trial;
   logic                  root_ge;
   logic                  load_out;
   logic                  is_sample;

   assign mag       = item_ff.scaled[SAMPLE_W-1] ? (SAMPLE_W'(0) - item_ff.scaled)
                                                 : item_ff.scaled;
   assign acc_sum   = {1'b0, energy_ff} + {{(ENERGY_W+1-SQ_W){1'b0}}, mul_ff[SQ_W-1:0]};
   assign acc_sat   = acc_sum[ENERGY_W] ? '1 : acc_sum[ENERGY_W-1:0];
   assign cnt_next  = count_ff + 1'b1;
   assign close     = item_ff.last || (cnt_next >= CW'(BLOCK_MAX));
   assign trial     = {rem_ff, work_ff[ENERGY_W-1]};
   assign trial_diff = trial - {1'b0, div_ff};
   assign div_ge    = (trial >= {1'b0, div_ff});
   assign root_trial = res_ff + bit_ff;
   assign root_ge   = (work_ff >= root_trial);
   assign is_sample = (item_ff.op == OP_SAMPLE);
   assign load_out  = (state_ff == S_EMIT) && (!out_valid_ff || rsp_tready);
   assign queue_pop = (state_ff == S_IDLE) && !queue_empty;

   // One shared multiplier: square of the sample, level decay, and root boost.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_EXEC: begin
            if (is_sample) begin
               mul_a = MUL_A_W'(mag);
               mul_b = MUL_B_W'(mag);
            end else begin
               mul_a = MUL_A_W'(level_ff);
               mul_b = MUL_B_W'(cfg.decay_factor);
            end
         end
         S_BOOST: begin
            mul_a = res_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'({cfg.level_boost, 1'b0});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_in = MUL_W'(mul_a) * MUL_W'(mul_b);

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      energy_in = energy_ff;
      count_in  = count_ff;
      div_in    = div_ff;
      level_in  = level_ff;
      work_in   = work_ff;
      rem_in    = rem_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      step_in   = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               item_in  = queue_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (item_ff.op)
               OP_SAMPLE: state_in = S_ACCUM;
               OP_TICK:   state_in = S_DECAY;
               OP_FLUSH: begin
                  level_in  = '0;
                  energy_in = '0;
                  count_in  = '0;
                  state_in  = S_EMIT;
               end
               default:   state_in = S_EMIT;
            endcase
         end
         S_ACCUM: begin
            if (close) begin
               work_in   = acc_sat;
               div_in    = cnt_next;
               energy_in = '0;
               count_in  = '0;
               rem_in    = '0;
               step_in   = '0;
               state_in  = S_DIV;
            end else begin
               energy_in = acc_sat;
               count_in  = cnt_next;
               state_in  = S_EMIT;
            end
         end
         S_DIV: begin
            // Restoring division, one quotient bit per cycle.
            rem_in  = div_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
            work_in = {work_ff[ENERGY_W-2:0], div_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ENERGY_W - 1)) begin
               res_in   = '0;
               bit_in   = ENERGY_W'(1) << (ENERGY_W - 2);
               step_in  = '0;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            // Digit-by-digit square root, one result bit per cycle.
            if (root_ge) begin
               work_in = work_ff - root_trial;
               res_in  = (res_ff >> 1) + bit_ff;
            end else begin
               res_in  = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               state_in = S_BOOST;
            end
         end
         S_BOOST: state_in = S_CLAMP;
         S_CLAMP: begin
            level_in = (mul_ff > MUL_W'(16'hFFFF)) ? 16'hFFFF : mul_ff[LEVEL_W-1:0];
            state_in = S_EMIT;
         end
         S_DECAY: begin
            level_in = mul_ff[2*LEVEL_W-1:LEVEL_W];
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         energy_ff    <= '0;
         count_ff     <= '0;
         level_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         energy_ff    <= energy_in;
         count_ff     <= count_in;
         level_ff     <= level_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      div_ff  <= div_in;
      mul_ff  <= mul_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      step_ff <= step_in;
      if (load_out) begin
         out_user_ff   <= is_sample;
         out_sample_ff <= is_sample ? item_ff.scaled : '0;
         out_level_ff  <= level_ff;
      end
   end

   assign rsp_tvalid       = out_valid_ff;
   assign rsp_sample_valid = out_user_ff;
   assign rsp_sample       = out_sample_ff;
   assign rsp_level        = out_level_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < CW'(BLOCK_MAX))
      else $error("block count reached the block limit without closing");
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_ff != '0))
      else $error("division started with a zero sample count");
   a_level_idle_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> $stable(level_ff))
      else $error("level changed while no item was in progress");
   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BOOST) |-> (res_ff[ENERGY_W-1:ROOT_W] == '0))
      else $error("square root result wider than expected");
`endif

endmodule

>>> hw/rtl/audio_gain_stereo_rms_meter_top.sv
// Top level of the PCM volume scaler with RMS level meter.
//
// Items enter on the req_ channel: req_tuser carries the kind (sample, idle tick,
// flush), req_tdata the signed mono sample and req_tlast the end of a block.
// Every item gives exactly one result on the rsp_ channel: rsp_tuser is high when
// the result carries a scaled sample, and rsp_tdata holds left, right and level.
// Registers are written on the csr_ channel, which is always ready; they are meant
// to change only while no item is in flight.
// A sample is scaled in the front end, which takes one item per cycle while the
// queue has room. The back end runs a sequencer with one shared multiplier and
// takes a new item only once the last result is in the output register. A sample
// passes the idle, execute, accumulate and emit states, a tick the idle, execute,
// decay and emit states, and a flush or an unused kind goes from execute to emit.
// A sample that closes a block adds the bit-serial division of the energy by the
// sample count, the bit-serial square root, and the boost and clamp steps.
// When the receiver stalls, the result waits in the output register, the back end
// holds its next result, and the queue and the front end fill up before req_tready
// falls. Reset clears the energy, sample count and level, empties the queue and
// the output register, and loads the register defaults.
module audio_gain_stereo_rms_meter_top #(
   parameter int BLOCK_MAX   = agsr_pkg::BLOCK_MAX_DEF,
   parameter int QUEUE_DEPTH = agsr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [agsr_pkg::SAMPLE_W-1:0]   req_tdata,   // sample_in
   input  logic [agsr_pkg::OP_W-1:0]       req_tuser,   // operation
   input  logic                            req_tlast,   // block_end
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [3*agsr_pkg::SAMPLE_W-1:0] rsp_tdata,   // left_out, right_out, level_out
   output logic                            rsp_tuser,   // sample_valid
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [agsr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [agsr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import agsr_pkg::*;

   agsr_cfg_type        cfg_ff, cfg_in;
   logic                csr_write;
   logic                queue_full;
   logic                queue_empty;
   logic                queue_push;
   logic                queue_pop;
   agsr_item_type       push_item;
   agsr_item_type       head_item;
   logic [SAMPLE_W-1:0] rsp_sample;
   logic [LEVEL_W-1:0]  rsp_level;

   // Register writes are never stalled: csr_ready is tied high.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_VOLUME_GAIN:  cfg_in.volume_gain  = csr_wdata[GAIN_W-1:0];
            CSR_LEVEL_BOOST:  cfg_in.level_boost  = csr_wdata[BOOST_W-1:0];
            CSR_DECAY_FACTOR: cfg_in.decay_factor = csr_wdata[DECAY_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{volume_gain: VOLUME_GAIN_RST,
                     level_boost: LEVEL_BOOST_RST,
                     decay_factor: DECAY_FACTOR_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   agsr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .volume_gain (cfg_ff.volume_gain),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_item  (push_item)
   );

   agsr_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (push_item),
      .pop       (queue_pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   agsr_back #(
      .BLOCK_MAX (BLOCK_MAX)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .queue_empty      (queue_empty),
      .queue_item       (head_item),
      .queue_pop        (queue_pop),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_sample_valid (rsp_tuser),
      .rsp_sample       (rsp_sample),
      .rsp_level        (rsp_level)
   );

   // The mono result goes out on both stereo channels.
   assign rsp_tdata = {rsp_level, rsp_sample, rsp_sample};

endmodule

>>> tb/sv/audio_gain_stereo_rms_meter_top_tb.sv
// Self-checking testbench of the PCM volume scaler with RMS level meter.
module audio_gain_stereo_rms_meter_top_tb;
   import agsr_pkg::*;

   // The item kind that the block must leave without effect.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [ENERGY_W-1:0] ENERGY_SAT = {ENERGY_W{1'b1}};
   localparam int IDLE_PERCENT   = 14;
   localparam int SETTLE_CYCLES  = 80;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 110;

   // One result as the receiver sees it.
   typedef struct packed {
      logic                       sample_valid;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic [LEVEL_W-1:0]         level;
   } stereo_result_type;

   logic clock = 1'b0;
   logic reset;

   logic                     req_tvalid;
   logic                     req_tready;
   logic [SAMPLE_W-1:0]      req_tdata;
   logic [OP_W-1:0]          req_tuser;
   logic                     req_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [3*SAMPLE_W-1:0]    rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   // Register copies and meter state, kept in step with every accepted item.
   logic [GAIN_W-1:0]   gain_reg;
   logic [BOOST_W-1:0]  boost_reg;
   logic [DECAY_W-1:0]  decay_reg;
   logic [ENERGY_W-1:0] energy_acc;
   int                  block_fill;
   logic [LEVEL_W-1:0]  level_q16;

   stereo_result_type pending_results[$];
   stereo_result_type oldest;
   int             error_count = 0;
   int             quiet_cycles = 0;
   bit             idle_enabled = 1'b1;

   audio_gain_stereo_rms_meter_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Floored square root, built one result bit at a time from the top down.
   function automatic logic [ROOT_W-1:0] floor_sqrt(logic [ENERGY_W-1:0] value);
      logic [ROOT_W-1:0] root;
      logic [ROOT_W-1:0] trial;
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (ROOT_W'(1) << b);
         if (ENERGY_W'(trial) * ENERGY_W'(trial) <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Applies one item to the meter state and returns the result it must cause.
   function automatic stereo_result_type scale_and_meter(logic [OP_W-1:0] op,
                                                         logic signed [SAMPLE_W-1:0] pcm,
                                                         logic block_end);
      stereo_result_type         res;
      longint                    product;
      longint                    quotient;
      logic signed [SAMPLE_W-1:0] scaled;
      logic [ENERGY_W-1:0]       square;
      logic [ENERGY_W:0]         total;
      logic [ENERGY_W-1:0]       mean_square;
      longint unsigned           boosted;
      logic [2*LEVEL_W-1:0]      decayed;
      scaled = '0;
      case (op)
         OP_SAMPLE: begin
            // Q2.14 gain, quotient truncated toward zero, then saturated.
            product  = longint'(pcm) * longint'({1'b0, gain_reg});
            quotient = product / 16384;
            if (quotient > 32767) quotient = 32767;
            if (quotient < -32768) quotient = -32768;
            scaled = quotient[SAMPLE_W-1:0];
            square = ENERGY_W'(longint'(scaled) * longint'(scaled));
            total  = {1'b0, energy_acc} + {1'b0, square};
            energy_acc = (total > {1'b0, ENERGY_SAT}) ? ENERGY_SAT : total[ENERGY_W-1:0];
            block_fill++;
            // A full block closes even without block_end.
            if (block_end || block_fill >= BLOCK_MAX_DEF) begin
               mean_square = energy_acc / ENERGY_W'(block_fill);
               boosted = longint'(floor_sqrt(mean_square)) * 2 * longint'(boost_reg);
               level_q16 = (boosted > 65535) ? 16'hFFFF : boosted[LEVEL_W-1:0];
               energy_acc = '0;
               block_fill = 0;
            end
         end
         OP_TICK: begin
            decayed = level_q16 * decay_reg;
            level_q16 = decayed[2*LEVEL_W-1:LEVEL_W];
         end
         OP_FLUSH: begin
            level_q16  = '0;
            energy_acc = '0;
            block_fill = 0;
         end
         default: begin
         end
      endcase
      res.sample_valid = (op == OP_SAMPLE);
      res.left  = scaled;
      res.right = scaled;
      res.level = level_q16;
      return res;
   endfunction

   // Sample values spread over all magnitudes, with the extremes now and then.
   function automatic logic signed [SAMPLE_W-1:0] random_pcm();
      logic signed [SAMPLE_W-1:0] raw;
      raw = SAMPLE_W'($urandom);
      case ($urandom_range(0, 19))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return raw >>> $urandom_range(0, 15);
      endcase
   endfunction

   // Receiver side: ready drops at random while idling is enabled.
   always @(negedge clock) begin
      rsp_tready <= !(idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT);
   end

   // Every accepted result is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result with no item waiting: tuser %0b tdata %h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_tuser !== oldest.sample_valid) begin
               $error("sample_valid: expected %0b, actual %0b", oldest.sample_valid, rsp_tuser);
               error_count++;
            end
            if ($signed(rsp_tdata[SAMPLE_W-1:0]) !== oldest.left) begin
               $error("left_out: expected %0d, actual %0d", oldest.left,
                      $signed(rsp_tdata[SAMPLE_W-1:0]));
               error_count++;
            end
            if ($signed(rsp_tdata[2*SAMPLE_W-1:SAMPLE_W]) !== oldest.right) begin
               $error("right_out: expected %0d, actual %0d", oldest.right,
                      $signed(rsp_tdata[2*SAMPLE_W-1:SAMPLE_W]));
               error_count++;
            end
            if (rsp_tdata[3*SAMPLE_W-1:2*SAMPLE_W] !== oldest.level) begin
               $error("level_out: expected %0d, actual %0d", oldest.level,
                      rsp_tdata[3*SAMPLE_W-1:2*SAMPLE_W]);
               error_count++;
            end
         end
      end
   end

   // The run is stopped when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[audio_gain_stereo_rms_meter_top] ERROR");
            $finish;
         end
      end
   end

   // Offers one item and predicts its result once it is taken. It is entered at
   // a falling edge and returns at the falling edge after acceptance, with valid
   // still high, so back-to-back items never lower and raise valid in one step.
   task automatic send_item(logic [OP_W-1:0] op, logic signed [SAMPLE_W-1:0] pcm,
                            logic block_end);
      while (idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= pcm;
      req_tlast  <= block_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(scale_and_meter(op, pcm, block_end));
      @(negedge clock);
   endtask

   // Holds the sender off until every predicted result has been seen.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Writes all three registers back to back; only called with nothing in flight.
   task automatic apply_settings(logic [GAIN_W-1:0] gain, logic [BOOST_W-1:0] boost,
                                 logic [DECAY_W-1:0] decay);
      logic [CSR_INDEX_W-1:0] indexes [3];
      logic [CSR_DATA_W-1:0]  values [3];
      indexes = '{CSR_VOLUME_GAIN, CSR_LEVEL_BOOST, CSR_DECAY_FACTOR};
      values  = '{gain, CSR_DATA_W'(boost), decay};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= indexes[i];
         csr_wdata <= values[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (indexes[i])
            CSR_VOLUME_GAIN:  gain_reg  = values[i];
            CSR_LEVEL_BOOST:  boost_reg = values[i][BOOST_W-1:0];
            CSR_DECAY_FACTOR: decay_reg = values[i];
            default: ;
         endcase
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Reset settings: sample extremes, alternating bit patterns, a tick inside an
   // open block, the unused kind, a flush in the middle of a block and a block
   // of a single sample.
   task automatic test_directed_extremes();
      send_item(OP_SAMPLE, 16'sh0000, 1'b0);
      send_item(OP_SAMPLE, 16'sh7FFF, 1'b0);
      send_item(OP_SAMPLE, 16'sh8000, 1'b0);
      send_item(OP_SAMPLE, 16'shFFFF, 1'b0);
      send_item(OP_TICK,   16'sh0000, 1'b0);
      send_item(OP_SAMPLE, 16'sh0001, 1'b0);
      send_item(OP_SAMPLE, 16'sh5555, 1'b0);
      send_item(OP_SAMPLE, 16'shAAAA, 1'b1);
      send_item(OP_TICK,   16'shFFFF, 1'b1);
      send_item(OP_TICK,   16'sh0000, 1'b0);
      send_item(OP_UNUSED, 16'shFFFF, 1'b1);
      send_item(OP_FLUSH,  16'sh1234, 1'b1);
      send_item(OP_TICK,   16'sh0000, 1'b0);
      send_item(OP_SAMPLE, 16'sh0064, 1'b1);
      send_item(OP_TICK,   16'sh0000, 1'b0);
      send_item(OP_UNUSED, 16'sh0000, 1'b0);
      send_item(OP_SAMPLE, -16'sd100, 1'b0);
      send_item(OP_FLUSH,  16'sh0000, 1'b0);
      send_item(OP_SAMPLE, 16'sh0032, 1'b1);
      wait_for_results();
   endtask

   // Register extremes: saturating gain, zero gain, zero boost, boost above 16,
   // decay of zero and of full scale, and gains that truncate toward zero.
   task automatic test_register_extremes();
      apply_settings(16'hFFFF, 5'd16, 16'h0000);
      send_item(OP_SAMPLE, 16'sh7FFF, 1'b0);
      send_item(OP_SAMPLE, 16'sh8000, 1'b0);
      send_item(OP_SAMPLE, 16'sd20000, 1'b0);
      send_item(OP_SAMPLE, -16'sd20000, 1'b1);
      send_item(OP_TICK, 16'sh0000, 1'b0);
      wait_for_results();

      apply_settings(16'h0000, 5'd4, 16'hFFFF);
      send_item(OP_SAMPLE, 16'sh7FFF, 1'b0);
      send_item(OP_SAMPLE, 16'sh8000, 1'b1);
      wait_for_results();

      apply_settings(16'd16384, 5'd0, 16'hFFFF);
      send_item(OP_SAMPLE, 16'sd1000, 1'b1);
      wait_for_results();

      apply_settings(16'd16384, 5'd1, 16'hFFFF);
      send_item(OP_SAMPLE, 16'sd1000, 1'b1);
      send_item(OP_TICK, 16'sh0000, 1'b0);
      wait_for_results();

      apply_settings(16'd24576, 5'd31, 16'd1);
      send_item(OP_SAMPLE, 16'shFFFF, 1'b0);
      send_item(OP_SAMPLE, 16'sh0001, 1'b0);
      send_item(OP_SAMPLE, -16'sd3, 1'b1);
      send_item(OP_TICK, 16'sh0000, 1'b0);
      wait_for_results();

      apply_settings(16'd1, 5'd17, 16'hFFFF);
      send_item(OP_SAMPLE, 16'sh8000, 1'b0);
      send_item(OP_SAMPLE, -16'sd16383, 1'b0);
      send_item(OP_SAMPLE, 16'sh7FFF, 1'b1);
      wait_for_results();
   endtask

   // A block that never sees block_end must close itself at the size limit; the
   // samples after that start a fresh block.
   task automatic test_block_overrun();
      apply_settings(VOLUME_GAIN_RST, LEVEL_BOOST_RST, DECAY_FACTOR_RST);
      for (int i = 0; i < BLOCK_MAX_DEF + 10; i++) begin
         send_item(OP_SAMPLE, random_pcm(), 1'b0);
      end
      send_item(OP_SAMPLE, random_pcm(), 1'b1);
      wait_for_results();
   endtask

   // Mostly well-formed blocks with random content, spiced with ticks, flushes
   // and the unused kind. One phase runs with no idling on either side.
   task automatic test_random_traffic();
      int sent;
      int block_len;
      int pick;
      logic [GAIN_W-1:0]  gain;
      logic [BOOST_W-1:0] boost;
      logic [DECAY_W-1:0] decay;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0: gain = 16'h0000;
            1: gain = 16'hFFFF;
            2: gain = 16'd16384;
            default: gain = GAIN_W'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0: boost = 5'd1;
            1: boost = 5'd16;
            default: boost = BOOST_W'($urandom_range(0, 31));
         endcase
         case ($urandom_range(0, 3))
            0: decay = 16'h0000;
            1: decay = 16'hFFFF;
            2: decay = DECAY_FACTOR_RST;
            default: decay = DECAY_W'($urandom);
         endcase
         apply_settings(gain, boost, decay);
         idle_enabled = (phase != 2);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
               // Most blocks are short so that many of them close.
               block_len = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 300)
                                                        : $urandom_range(1, 16);
               for (int i = 0; i < block_len; i++) begin
                  if ($urandom_range(0, 99) < 5) begin
                     send_item(OP_TICK, SAMPLE_W'($urandom), 1'($urandom));
                     sent++;
                  end
                  send_item(OP_SAMPLE, random_pcm(), i == block_len - 1);
                  sent++;
               end
            end else if (pick < 93) begin
               repeat ($urandom_range(1, 4)) begin
                  send_item(OP_TICK, SAMPLE_W'($urandom), 1'($urandom));
                  sent++;
               end
            end else if (pick < 97) begin
               send_item(OP_FLUSH, SAMPLE_W'($urandom), 1'($urandom));
               sent++;
            end else begin
               send_item(OP_UNUSED, SAMPLE_W'($urandom), 1'($urandom));
            end
         end
         wait_for_results();
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_SAMPLE;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_VOLUME_GAIN;
      csr_wdata  = '0;
      gain_reg   = VOLUME_GAIN_RST;
      boost_reg  = LEVEL_BOOST_RST;
      decay_reg  = DECAY_FACTOR_RST;
      energy_acc = '0;
      block_fill = 0;
      level_q16  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_extremes();
      test_register_extremes();
      test_block_overrun();
      test_random_traffic();

      // Everything has been answered; give a late extra result time to show up.
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("[audio_gain_stereo_rms_meter_top] OK");
      end else begin
         $display("[audio_gain_stereo_rms_meter_top] ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/agsr_pkg.sv
hw/rtl/agsr_front.sv
hw/rtl/agsr_fifo.sv
hw/rtl/agsr_back.sv
hw/rtl/audio_gain_stereo_rms_meter_top.sv
tb/sv/audio_gain_stereo_rms_meter_top_tb.sv
